// ===== hdl/lcg48_pkg.sv =====
// Package for the 48-bit LCG generator: constants, action codes, sequencer states.
// No dependencies.
package lcg48_pkg;
    localparam logic [47:0] LCG_MULT = 48'h0005_DEEC_E66D;
    localparam logic [47:0] LCG_ADD  = 48'h0000_0000_000B;
    localparam logic [63:0] REGION_KX = 64'd341873128712;
    localparam logic [63:0] REGION_KZ = 64'd132897987541;
    localparam int STATE_W = 48;

    typedef enum logic [2:0] {
        ACT_SEED   = 3'd0,
        ACT_CARVER = 3'd1,
        ACT_REGION = 3'd2,
        ACT_BITS   = 3'd3,
        ACT_BOUND  = 3'd4,
        ACT_LONG   = 3'd5,
        ACT_FLOAT  = 3'd6,
        ACT_DOUBLE = 3'd7
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAW,
        ST_MIX1,
        ST_MIX2,
        ST_DIV,
        ST_DONE
    } state_t;
endpackage

// ===== hdl/lcg48_random_generator.sv =====
// Top level of the 48-bit LCG generator: sequencer around a shared multiplier and divider.
// Depends on lcg48_pkg, lcg48_mul, lcg48_div.
//
// Channel | Direction | Signals
// s_      | in        | s_valid s_ready s_action s_seed_value s_coord_x s_coord_z s_salt
//         |           | s_bound s_bits
// m_      | out       | m_valid m_ready m_value
//
// Every state step is one pass of the multiplier plus sequencing.
// Plain seed uses no multiplier pass; region seed takes 2 products; each draw takes one step;
// carver seed takes 4 steps and 2 products; a non-power-of-two bound adds a divider pass.
// One request at a time; s_ready is low from acceptance until the result is taken.
// Synchronous active-low reset clears the state to zero.
module lcg48_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic signed [63:0] s_seed_value,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_z,
    input  logic signed [31:0] s_salt,
    input  logic [30:0] s_bound,
    input  logic [5:0]  s_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [63:0] m_value
);
    lcg48_pkg::state_t st_reg, st_next;
    logic [47:0] lcg_reg, lcg_next;
    logic [2:0]  act_reg, act_next;
    logic [63:0] seed_reg, seed_next;
    logic [63:0] x_reg, x_next, z_reg, z_next, salt_reg, salt_next;
    logic [30:0] bound_reg, bound_next;
    logic [5:0]  bits_reg, bits_next;
    logic [63:0] val_reg, val_next;
    logic [63:0] a_reg, a_next, hold_reg, hold_next;
    logic [1:0]  ndraw_reg, ndraw_next;
    logic [63:0] mul_a, mul_b, prod;
    logic        mul_start, mul_done, div_start, div_done;
    logic [30:0] rem;
    logic [47:0] stepped;
    logic [5:0]  nb;
    logic [31:0] top;
    logic [63:0] drawn;
    logic        pow2;

    lcg48_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
        .done(mul_done), .product(prod)
    );

    lcg48_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(drawn[30:0]),
        .divisor(bound_reg), .done(div_done), .remainder(rem)
    );

    always_comb begin
        stepped = prod[47:0] + lcg48_pkg::LCG_ADD;
        unique case (act_reg)
            lcg48_pkg::ACT_BITS:   nb = (bits_reg > 6'd32) ? 6'd32 : bits_reg;
            lcg48_pkg::ACT_BOUND:  nb = 6'd31;
            lcg48_pkg::ACT_FLOAT:  nb = 6'd24;
            lcg48_pkg::ACT_DOUBLE: nb = (ndraw_reg == 2'd0) ? 6'd26 : 6'd27;
            default:               nb = 6'd32;
        endcase
        top   = 32'(stepped >> (6'd48 - nb));
        drawn = (nb == 6'd0) ? 64'd0 : {{32{top[31]}}, top};
        pow2  = (bound_reg & (bound_reg - 31'd1)) == 31'd0;
    end

    always_comb begin
        st_next    = st_reg;
        lcg_next   = lcg_reg;
        act_next   = act_reg;
        seed_next  = seed_reg;
        x_next     = x_reg;
        z_next     = z_reg;
        salt_next  = salt_reg;
        bound_next = bound_reg;
        bits_next  = bits_reg;
        val_next   = val_reg;
        a_next     = a_reg;
        hold_next  = hold_reg;
        ndraw_next = ndraw_reg;
        mul_start  = 1'b0;
        mul_a      = {16'd0, lcg_reg};
        mul_b      = {16'd0, lcg48_pkg::LCG_MULT};
        div_start  = 1'b0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (st_reg)
            lcg48_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    act_next   = s_action;
                    seed_next  = s_seed_value;
                    x_next     = 64'(s_coord_x);
                    z_next     = 64'(s_coord_z);
                    salt_next  = 64'(s_salt);
                    bound_next = s_bound;
                    bits_next  = s_bits;
                    ndraw_next = 2'd0;
                    unique case (lcg48_pkg::action_t'(s_action))
                        lcg48_pkg::ACT_SEED: begin
                            lcg_next = s_seed_value[47:0] ^ lcg48_pkg::LCG_MULT;
                            val_next = {16'd0, lcg_next};
                            st_next  = lcg48_pkg::ST_DONE;
                        end
                        lcg48_pkg::ACT_CARVER: begin
                            lcg_next = s_seed_value[47:0] ^ lcg48_pkg::LCG_MULT;
                            st_next  = lcg48_pkg::ST_MUL;
                        end
                        lcg48_pkg::ACT_REGION: begin
                            st_next = lcg48_pkg::ST_MIX1;
                        end
                        default: st_next = lcg48_pkg::ST_MUL;
                    endcase
                end
            end
            lcg48_pkg::ST_MUL: begin
                mul_start = 1'b1;
                st_next   = lcg48_pkg::ST_DRAW;
            end
            lcg48_pkg::ST_DRAW: begin
                if (mul_done) begin
                    lcg_next = stepped;
                    unique case (act_reg)
                        lcg48_pkg::ACT_LONG, lcg48_pkg::ACT_CARVER: begin
                            if (!ndraw_reg[0]) begin
                                hold_next  = drawn;
                                ndraw_next = ndraw_reg + 2'd1;
                                st_next    = lcg48_pkg::ST_MUL;
                            end else begin
                                val_next = (hold_reg << 32) + drawn;
                                if (act_reg == lcg48_pkg::ACT_LONG) begin
                                    st_next = lcg48_pkg::ST_DONE;
                                end else if (ndraw_reg == 2'd1) begin
                                    a_next     = (hold_reg << 32) + drawn;
                                    ndraw_next = 2'd2;
                                    st_next    = lcg48_pkg::ST_MUL;
                                end else begin
                                    st_next = lcg48_pkg::ST_MIX1;
                                end
                            end
                        end
                        lcg48_pkg::ACT_DOUBLE: begin
                            if (ndraw_reg == 2'd0) begin
                                hold_next  = drawn;
                                ndraw_next = 2'd1;
                                st_next    = lcg48_pkg::ST_MUL;
                            end else begin
                                val_next = (hold_reg << 27) + drawn;
                                st_next  = lcg48_pkg::ST_DONE;
                            end
                        end
                        lcg48_pkg::ACT_BOUND: begin
                            if (pow2) begin
                                val_next = 64'((62'(bound_reg) * 62'(drawn[30:0])) >> 31);
                                st_next  = lcg48_pkg::ST_DONE;
                            end else begin
                                div_start = 1'b1;
                                st_next   = lcg48_pkg::ST_DIV;
                            end
                        end
                        default: begin
                            val_next = drawn;
                            st_next  = lcg48_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            lcg48_pkg::ST_DIV: begin
                if (div_done) begin
                    val_next = {33'd0, rem};
                    st_next  = lcg48_pkg::ST_DONE;
                end
            end
            lcg48_pkg::ST_MIX1: begin
                mul_a     = x_reg;
                mul_b     = (act_reg == lcg48_pkg::ACT_CARVER) ? a_reg : lcg48_pkg::REGION_KX;
                mul_start = 1'b1;
                hold_next = val_reg;
                st_next   = lcg48_pkg::ST_MIX2;
            end
            lcg48_pkg::ST_MIX2: begin
                if (mul_done) begin
                    if (act_reg == lcg48_pkg::ACT_CARVER) begin
                        seed_next = seed_reg ^ prod;
                        x_next    = z_reg;
                        a_next    = hold_reg;
                        act_next  = lcg48_pkg::ACT_SEED;
                        st_next   = lcg48_pkg::ST_MIX1;
                    end else if (act_reg == lcg48_pkg::ACT_REGION) begin
                        seed_next = seed_reg + salt_reg + prod;
                        x_next    = z_reg;
                        act_next  = lcg48_pkg::ACT_BITS;
                        st_next   = lcg48_pkg::ST_MIX1;
                    end else begin
                        if (act_reg == lcg48_pkg::ACT_SEED) begin
                            lcg_next = seed_reg[47:0] ^ prod[47:0] ^ lcg48_pkg::LCG_MULT;
                        end else begin
                            lcg_next = seed_reg[47:0] + prod[47:0] ^ lcg48_pkg::LCG_MULT;
                        end
                        val_next = {16'd0, lcg_next};
                        st_next  = lcg48_pkg::ST_DONE;
                    end
                end
            end
            lcg48_pkg::ST_DONE: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    st_next = lcg48_pkg::ST_IDLE;
                end
            end
            default: st_next = lcg48_pkg::ST_IDLE;
        endcase
        if (st_reg == lcg48_pkg::ST_MIX1) begin
            if (act_reg == lcg48_pkg::ACT_SEED) begin
                mul_b = a_reg;
            end else if (act_reg == lcg48_pkg::ACT_BITS) begin
                mul_b = lcg48_pkg::REGION_KZ;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= lcg48_pkg::ST_IDLE;
            lcg_reg <= 48'd0;
        end else begin
            st_reg  <= st_next;
            lcg_reg <= lcg_next;
        end
        act_reg   <= act_next;
        seed_reg  <= seed_next;
        x_reg     <= x_next;
        z_reg     <= z_next;
        salt_reg  <= salt_next;
        bound_reg <= bound_next;
        bits_reg  <= bits_next;
        val_reg   <= val_next;
        a_reg     <= a_next;
        hold_reg  <= hold_next;
        ndraw_reg <= ndraw_next;
    end

    assign m_value = val_reg;
endmodule

// ===== hdl/lcg48_mul.sv =====
// Shared shift-add multiplier, 4 bits of multiplier per cycle, 64-bit wrapping product.
// No package dependencies.
module lcg48_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] product
);
    logic [63:0] acc_reg, acc_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [63:0] part;

    always_comb begin
        part = 64'd0;
        for (int i = 0; i < 4; i++) begin
            if (b_reg[i]) begin
                part = part + (a_reg << i);
            end
        end
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            acc_next  = 64'd0;
            a_next    = op_a;
            b_next    = op_b;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc_reg + part;
            a_next   = a_reg << 4;
            b_next   = b_reg >> 4;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = busy_reg && (cnt_reg == 5'd15);
    assign product = acc_reg + part;
endmodule

// ===== hdl/lcg48_div.sv =====
// Restoring divider, one quotient bit per cycle, 31-bit remainder only.
// No package dependencies.
module lcg48_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [30:0] dividend,
    input  logic [30:0] divisor,
    output logic        done,
    output logic [30:0] remainder
);
    logic [31:0] rem_reg, rem_next;
    logic [30:0] num_reg, num_next;
    logic [30:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [31:0] trial;

    always_comb begin
        trial     = {rem_reg[30:0], num_reg[30]};
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = 32'd0;
            num_next  = dividend;
            den_next  = divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[29:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign done      = busy_reg && (cnt_reg == 5'd30);
    assign remainder = rem_next[30:0];
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for lcg48_random_generator: directed and random requests,
// expected values computed by an in-bench LCG48 predictor. Depends on lcg48_pkg and lcg48_random_generator.
`timescale 1ns / 1ps

module tb_top;
    localparam logic [47:0] MULT = 48'h0005_DEEC_E66D;
    localparam logic [47:0] ADDC = 48'h0000_0000_000B;
    localparam logic [63:0] KX   = 64'd341873128712;
    localparam logic [63:0] KZ   = 64'd132897987541;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic signed [63:0] s_seed_value = '0;
    logic signed [31:0] s_coord_x = '0;
    logic signed [31:0] s_coord_z = '0;
    logic signed [31:0] s_salt = '0;
    logic [30:0] s_bound = '0;
    logic [5:0]  s_bits = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [63:0] m_value;

    lcg48_random_generator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_seed_value(s_seed_value), .s_coord_x(s_coord_x), .s_coord_z(s_coord_z),
        .s_salt(s_salt), .s_bound(s_bound), .s_bits(s_bits),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    logic [47:0] model_state = '0;
    logic [63:0] expected_values[$];
    int          errors = 0;
    int          results_seen = 0;
    int          action_hits[8];
    bit          no_idle = 1'b0;

    function automatic logic [63:0] sx32(logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] step_bits(int n);
        logic [47:0] s;
        s = model_state * MULT + ADDC;
        model_state = s;
        if (n == 0) return '0;
        if (n > 32) n = 32;
        return sx32(32'(s >> (48 - n)));
    endfunction

    function automatic logic [63:0] step_long();
        logic [63:0] hi, lo;
        hi = step_bits(32);
        lo = step_bits(32);
        return (hi << 32) + lo;
    endfunction

    function automatic void load_seed(logic [63:0] s);
        model_state = s[47:0] ^ MULT;
    endfunction

    function automatic logic [63:0] predict_value(logic [2:0] act, logic [63:0] seed,
            logic [31:0] x, logic [31:0] z, logic [31:0] salt, logic [30:0] bnd,
            logic [5:0] nb);
        logic [63:0] a, b, r, bb;
        case (lcg48_pkg::action_t'(act))
            lcg48_pkg::ACT_SEED: begin
                load_seed(seed);
                return {16'd0, model_state};
            end
            lcg48_pkg::ACT_CARVER: begin
                load_seed(seed);
                a = step_long();
                b = step_long();
                load_seed((sx32(x) * a) ^ (sx32(z) * b) ^ seed);
                return {16'd0, model_state};
            end
            lcg48_pkg::ACT_REGION: begin
                load_seed(sx32(x) * KX + sx32(z) * KZ + seed + sx32(salt));
                return {16'd0, model_state};
            end
            lcg48_pkg::ACT_BITS: return step_bits(int'(nb));
            lcg48_pkg::ACT_BOUND: begin
                r = step_bits(31);
                bb = {33'd0, bnd};
                if ((bb & (bb - 64'd1)) == 64'd0) return (bb * r) >> 31;
                return r % bb;
            end
            lcg48_pkg::ACT_LONG: return step_long();
            lcg48_pkg::ACT_FLOAT: return step_bits(24);
            default: begin
                a = step_bits(26);
                b = step_bits(27);
                return (a << 27) + b;
            end
        endcase
    endfunction

    task automatic send_request(logic [2:0] act, logic [63:0] seed, logic [31:0] x,
            logic [31:0] z, logic [31:0] salt, logic [30:0] bnd, logic [5:0] nb);
        while (!no_idle && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_seed_value <= seed;
        s_coord_x <= x;
        s_coord_z <= z;
        s_salt <= salt;
        s_bound <= bnd;
        s_bits <= nb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_values.push_back(predict_value(act, seed, x, z, salt, bnd, nb));
        action_hits[act]++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_values.size() == 0) begin
                    $error("unexpected result value=%h", m_value);
                    errors++;
                end else begin
                    if (m_value !== expected_values[0]) begin
                        $error("value mismatch: expected %h actual %h",
                            expected_values[0], m_value);
                        errors++;
                    end
                    void'(expected_values.pop_front());
                end
            end
            m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 18);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_values.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_request(lcg48_pkg::ACT_SEED, 64'h8000_0000_0000_0000, 32'd0, 32'd0, 32'd0,
            31'd1, 6'd1);
        send_request(lcg48_pkg::ACT_SEED, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 32'd0,
            31'd1, 6'd1);
        send_request(lcg48_pkg::ACT_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 32'd0,
            31'd1, 6'd1);
        send_request(lcg48_pkg::ACT_BITS, 64'd0, 32'd0, 32'd0, 32'd0, 31'd0, 6'd0);
        send_request(lcg48_pkg::ACT_BITS, 64'd0, 32'd0, 32'd0, 32'd0, 31'd0, 6'd1);
        send_request(lcg48_pkg::ACT_BITS, 64'd0, 32'd0, 32'd0, 32'd0, 31'd0, 6'd32);
        send_request(lcg48_pkg::ACT_BITS, 64'd0, 32'd0, 32'd0, 32'd0, 31'd0, 6'd63);
        send_request(lcg48_pkg::ACT_BOUND, 64'd0, 32'd0, 32'd0, 32'd0, 31'd0, 6'd0);
        send_request(lcg48_pkg::ACT_BOUND, 64'd0, 32'd0, 32'd0, 32'd0, 31'd1, 6'd0);
        send_request(lcg48_pkg::ACT_BOUND, 64'd0, 32'd0, 32'd0, 32'd0, 31'h4000_0000, 6'd0);
        send_request(lcg48_pkg::ACT_BOUND, 64'd0, 32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF, 6'd0);
        send_request(lcg48_pkg::ACT_BOUND, 64'd0, 32'd0, 32'd0, 32'd0, 31'd3, 6'd0);
        send_request(lcg48_pkg::ACT_LONG, 64'd0, 32'd0, 32'd0, 32'd0, 31'd0, 6'd0);
        send_request(lcg48_pkg::ACT_FLOAT, 64'd0, 32'd0, 32'd0, 32'd0, 31'd0, 6'd0);
        send_request(lcg48_pkg::ACT_DOUBLE, 64'd0, 32'd0, 32'd0, 32'd0, 31'd0, 6'd0);
        send_request(lcg48_pkg::ACT_CARVER, 64'h8000_0000_0000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'd0, 31'd0, 6'd0);
        send_request(lcg48_pkg::ACT_CARVER, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
            32'h8000_0000, 32'd0, 31'd0, 6'd0);
        send_request(lcg48_pkg::ACT_REGION, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0000, 31'd0, 6'd0);
        send_request(lcg48_pkg::ACT_REGION, 64'h8000_0000_0000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0, 6'd0);
        send_request(lcg48_pkg::ACT_FLOAT, 64'd0, 32'd0, 32'd0, 32'd0, 31'd0, 6'd0);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        send_request(lcg48_pkg::ACT_DOUBLE, 64'd0, 32'd0, 32'd0, 32'd0, 31'd0, 6'd0);
    endtask

    task automatic test_random(int count);
        logic [30:0] bnd;
        logic [2:0]  act;
        for (int i = 0; i < count; i++) begin
            no_idle = (i >= 400 && i < 600);
            act = 3'($urandom_range(7));
            case ($urandom_range(3))
                0: bnd = 31'(1) << $urandom_range(30);
                1: bnd = 31'($urandom_range(255));
                default: bnd = 31'($urandom());
            endcase
            send_request(act, rand64(), $urandom(), $urandom(), $urandom(), bnd,
                6'($urandom_range(63)));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_drain_pause();
        test_random(1880);
        wait_drained();
        repeat (200) @(posedge aclk);
        $display("Covered %0d results: seed %0d carver %0d region %0d bits %0d bound %0d",
            results_seen, action_hits[0], action_hits[1], action_hits[2],
            action_hits[3], action_hits[4]);
        $display("long %0d float %0d double %0d, with random stalls on both sides",
            action_hits[5], action_hits[6], action_hits[7]);
        if (errors == 0 && expected_values.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
